// ===== design/imac_pkg.sv =====
`default_nettype none

package imac_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DW = 64;
  localparam int unsigned HW = DW / 2;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned IW = 48;
  localparam int unsigned RF_N = 30;
  localparam int unsigned PC_W = 7;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [IW-1:0] field_t;
  typedef logic [4:0] ridx_t;
  typedef logic [PC_W-1:0] pc_t;

  localparam word_t WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam word_t WORD_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [1:0] MK_LENGTH = 2'd0;
  localparam logic [1:0] MK_AREA   = 2'd1;

  // register file slots: body inputs, running sums, scratch
  localparam ridx_t RI_AMT = 5'd0;
  localparam ridx_t RI_SEC = 5'd1;
  localparam ridx_t RI_CX  = 5'd2;
  localparam ridx_t RI_CY  = 5'd3;
  localparam ridx_t RI_CZ  = 5'd4;
  localparam ridx_t RI_SX  = 5'd5;
  localparam ridx_t RI_SY  = 5'd6;
  localparam ridx_t RI_SZ  = 5'd7;
  localparam ridx_t RI_PXY = 5'd8;
  localparam ridx_t RI_PXZ = 5'd9;
  localparam ridx_t RI_PYZ = 5'd10;
  localparam ridx_t RI_A   = 5'd11;
  localparam ridx_t RI_S   = 5'd12;
  localparam ridx_t RI_F0  = 5'd13;
  localparam ridx_t RI_F1  = 5'd14;
  localparam ridx_t RI_F2  = 5'd15;
  localparam ridx_t RI_Q0  = 5'd16;
  localparam ridx_t RI_Q1  = 5'd17;
  localparam ridx_t RI_Q2  = 5'd18;
  localparam ridx_t RI_P0  = 5'd19;
  localparam ridx_t RI_P1  = 5'd20;
  localparam ridx_t RI_P2  = 5'd21;
  localparam ridx_t RI_T0  = 5'd22;
  localparam ridx_t RI_T1  = 5'd23;
  localparam ridx_t RI_T2  = 5'd24;
  localparam ridx_t RI_T3  = 5'd25;
  localparam ridx_t RI_T4  = 5'd26;
  localparam ridx_t RI_T5  = 5'd27;
  localparam ridx_t RI_T6  = 5'd28;
  localparam ridx_t RI_T7  = 5'd29;

  typedef enum logic [2:0] {
    OP_MUL, OP_DIV, OP_ADD, OP_ADDS, OP_SUB, OP_ZERO, OP_JMP, OP_END
  } op_t;

  typedef struct packed {
    op_t   op;
    ridx_t dst;
    ridx_t a;
    ridx_t b;
  } uop_t;

  typedef struct packed {
    logic ld_in;
    logic rd_a;
    logic rd_b;
    logic wr_alu;
    logic start_mdu;
    logic wr_mdu;
    logic out_load;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic mdu_done;
    logic out_free;
  } dp_sts_t;

  localparam pc_t PC_OUT = 7'd29;
  localparam pc_t PC_CLR = 7'd53;
  localparam pc_t PC_N   = 7'd65;

  function automatic uop_t mk(op_t op, ridx_t dst, ridx_t a, ridx_t b);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  function automatic uop_t prog(pc_t pc);
    uop_t u;
    unique case (pc)
      // body add: first moments, running sums
      7'd0:  u = mk(OP_MUL,  RI_T0,  RI_CX,  RI_AMT);
      7'd1:  u = mk(OP_MUL,  RI_T1,  RI_CY,  RI_AMT);
      7'd2:  u = mk(OP_MUL,  RI_T2,  RI_CZ,  RI_AMT);
      7'd3:  u = mk(OP_ADD,  RI_A,   RI_A,   RI_AMT);
      7'd4:  u = mk(OP_ADDS, RI_S,   RI_S,   RI_SEC);
      7'd5:  u = mk(OP_ADD,  RI_F0,  RI_F0,  RI_T0);
      7'd6:  u = mk(OP_ADD,  RI_F1,  RI_F1,  RI_T1);
      7'd7:  u = mk(OP_ADD,  RI_F2,  RI_F2,  RI_T2);
      7'd8:  u = mk(OP_MUL,  RI_T3,  RI_CX,  RI_T0);
      7'd9:  u = mk(OP_MUL,  RI_T4,  RI_CY,  RI_T1);
      7'd10: u = mk(OP_MUL,  RI_T5,  RI_CZ,  RI_T2);
      7'd11: u = mk(OP_ADD,  RI_T6,  RI_T4,  RI_T5);
      7'd12: u = mk(OP_ADD,  RI_T6,  RI_SX,  RI_T6);
      7'd13: u = mk(OP_ADD,  RI_Q0,  RI_Q0,  RI_T6);
      7'd14: u = mk(OP_ADD,  RI_T6,  RI_T3,  RI_T5);
      7'd15: u = mk(OP_ADD,  RI_T6,  RI_SY,  RI_T6);
      7'd16: u = mk(OP_ADD,  RI_Q1,  RI_Q1,  RI_T6);
      7'd17: u = mk(OP_ADD,  RI_T6,  RI_T3,  RI_T4);
      7'd18: u = mk(OP_ADD,  RI_T6,  RI_SZ,  RI_T6);
      7'd19: u = mk(OP_ADD,  RI_Q2,  RI_Q2,  RI_T6);
      7'd20: u = mk(OP_MUL,  RI_T6,  RI_CX,  RI_T1);
      7'd21: u = mk(OP_ADD,  RI_T6,  RI_PXY, RI_T6);
      7'd22: u = mk(OP_ADD,  RI_P0,  RI_P0,  RI_T6);
      7'd23: u = mk(OP_MUL,  RI_T6,  RI_CX,  RI_T2);
      7'd24: u = mk(OP_ADD,  RI_T6,  RI_PXZ, RI_T6);
      7'd25: u = mk(OP_ADD,  RI_P1,  RI_P1,  RI_T6);
      7'd26: u = mk(OP_MUL,  RI_T6,  RI_CY,  RI_T2);
      7'd27: u = mk(OP_ADD,  RI_T6,  RI_PYZ, RI_T6);
      7'd28: u = mk(OP_ADD,  RI_P2,  RI_P2,  RI_T6);
      // report: means, then moments about the combined centroid
      7'd29: u = mk(OP_DIV,  RI_T0,  RI_F0,  RI_A);
      7'd30: u = mk(OP_DIV,  RI_T1,  RI_F1,  RI_A);
      7'd31: u = mk(OP_DIV,  RI_T2,  RI_F2,  RI_A);
      7'd32: u = mk(OP_MUL,  RI_T3,  RI_T0,  RI_T0);
      7'd33: u = mk(OP_MUL,  RI_T4,  RI_T1,  RI_T1);
      7'd34: u = mk(OP_MUL,  RI_T5,  RI_T2,  RI_T2);
      7'd35: u = mk(OP_ADD,  RI_T6,  RI_T4,  RI_T5);
      7'd36: u = mk(OP_MUL,  RI_T6,  RI_A,   RI_T6);
      7'd37: u = mk(OP_SUB,  RI_SX,  RI_Q0,  RI_T6);
      7'd38: u = mk(OP_ADD,  RI_T6,  RI_T5,  RI_T3);
      7'd39: u = mk(OP_MUL,  RI_T6,  RI_A,   RI_T6);
      7'd40: u = mk(OP_SUB,  RI_SY,  RI_Q1,  RI_T6);
      7'd41: u = mk(OP_ADD,  RI_T6,  RI_T3,  RI_T4);
      7'd42: u = mk(OP_MUL,  RI_T6,  RI_A,   RI_T6);
      7'd43: u = mk(OP_SUB,  RI_SZ,  RI_Q2,  RI_T6);
      7'd44: u = mk(OP_MUL,  RI_T6,  RI_A,   RI_T0);
      7'd45: u = mk(OP_MUL,  RI_T7,  RI_T6,  RI_T1);
      7'd46: u = mk(OP_SUB,  RI_PXY, RI_P0,  RI_T7);
      7'd47: u = mk(OP_MUL,  RI_T7,  RI_T6,  RI_T2);
      7'd48: u = mk(OP_SUB,  RI_PXZ, RI_P1,  RI_T7);
      7'd49: u = mk(OP_MUL,  RI_T6,  RI_A,   RI_T1);
      7'd50: u = mk(OP_MUL,  RI_T7,  RI_T6,  RI_T2);
      7'd51: u = mk(OP_SUB,  RI_PYZ, RI_P2,  RI_T7);
      7'd52: u = mk(OP_END,  RI_T0,  RI_T0,  RI_T0);
      // clear
      7'd53: u = mk(OP_ZERO, RI_A,   RI_A,   RI_A);
      7'd54: u = mk(OP_ZERO, RI_S,   RI_S,   RI_S);
      7'd55: u = mk(OP_ZERO, RI_F0,  RI_F0,  RI_F0);
      7'd56: u = mk(OP_ZERO, RI_F1,  RI_F1,  RI_F1);
      7'd57: u = mk(OP_ZERO, RI_F2,  RI_F2,  RI_F2);
      7'd58: u = mk(OP_ZERO, RI_Q0,  RI_Q0,  RI_Q0);
      7'd59: u = mk(OP_ZERO, RI_Q1,  RI_Q1,  RI_Q1);
      7'd60: u = mk(OP_ZERO, RI_Q2,  RI_Q2,  RI_Q2);
      7'd61: u = mk(OP_ZERO, RI_P0,  RI_P0,  RI_P0);
      7'd62: u = mk(OP_ZERO, RI_P1,  RI_P1,  RI_P1);
      7'd63: u = mk(OP_ZERO, RI_P2,  RI_P2,  RI_P2);
      7'd64: u = mk(OP_JMP,  RI_T0,  RI_T0,  RI_T0);
      default: u = mk(OP_END, RI_T0, RI_T0, RI_T0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== design/inertia_moment_accumulator.sv =====
`default_nettype none
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | command, amount, secondary, centroid_*, spin_in_*, prod_in_*
// out     | out | out_valid/out_stall| total_*, mean_*, spin_out_*, prod_out_*, measure_ok
// cfg     | in  | cfg_valid/cfg_ready| measure_kind
//
// One word in flight from acceptance to result.
// The time is set by the shared multiply/divide unit: three divides per word
// for the means, and each multiply goes through one 32x32 multiplier.
// Reset (rst, synchronous) zeroes all sums and sets measure_kind to area.
// A finished word waits in the output register under out_stall; the next
// input word is taken meanwhile.

module inertia_moment_accumulator (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             command,
  input  imac_pkg::field_t amount,
  input  imac_pkg::field_t secondary,
  input  imac_pkg::field_t centroid_x,
  input  imac_pkg::field_t centroid_y,
  input  imac_pkg::field_t centroid_z,
  input  imac_pkg::field_t spin_in_x,
  input  imac_pkg::field_t spin_in_y,
  input  imac_pkg::field_t spin_in_z,
  input  imac_pkg::field_t prod_in_xy,
  input  imac_pkg::field_t prod_in_xz,
  input  imac_pkg::field_t prod_in_yz,
  output logic             out_valid,
  input  logic             out_stall,
  output imac_pkg::word_t  total_amount,
  output imac_pkg::word_t  total_secondary,
  output imac_pkg::word_t  mean_x,
  output imac_pkg::word_t  mean_y,
  output imac_pkg::word_t  mean_z,
  output imac_pkg::word_t  spin_out_x,
  output imac_pkg::word_t  spin_out_y,
  output imac_pkg::word_t  spin_out_z,
  output imac_pkg::word_t  prod_out_xy,
  output imac_pkg::word_t  prod_out_xz,
  output imac_pkg::word_t  prod_out_yz,
  output logic             measure_ok,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       measure_kind
);
  import imac_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  imac_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .measure_kind (measure_kind),
    .cmd          (cmd),
    .sts          (sts)
  );

  imac_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .amount          (amount),
    .secondary       (secondary),
    .centroid_x      (centroid_x),
    .centroid_y      (centroid_y),
    .centroid_z      (centroid_z),
    .spin_in_x       (spin_in_x),
    .spin_in_y       (spin_in_y),
    .spin_in_z       (spin_in_z),
    .prod_in_xy      (prod_in_xy),
    .prod_in_xz      (prod_in_xz),
    .prod_in_yz      (prod_in_yz),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .total_amount    (total_amount),
    .total_secondary (total_secondary),
    .mean_x          (mean_x),
    .mean_y          (mean_y),
    .mean_z          (mean_z),
    .spin_out_x      (spin_out_x),
    .spin_out_y      (spin_out_y),
    .spin_out_z      (spin_out_z),
    .prod_out_xy     (prod_out_xy),
    .prod_out_xz     (prod_out_xz),
    .prod_out_yz     (prod_out_yz),
    .measure_ok      (measure_ok)
  );

endmodule

`default_nettype wire

// ===== design/imac_mdu.sv =====
`default_nettype none

module imac_mdu (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           is_div,
  input  imac_pkg::word_t a,
  input  imac_pkg::word_t b,
  output logic           done,
  output imac_pkg::word_t result
);
  import imac_pkg::*;

  typedef enum logic [5:0] {
    MD_IDLE = 6'b000001,
    MD_MUL  = 6'b000010,
    MD_MNEG = 6'b000100,
    MD_MSAT = 6'b001000,
    MD_DIV  = 6'b010000,
    MD_DSAT = 6'b100000
  } md_state_t;

  md_state_t       state;
  logic [DW-1:0]   ua;
  logic [DW-1:0]   ub;
  logic            neg;
  logic [6:0]      cnt;
  logic [DW-1:0]   pp;
  logic [1:0]      pp_k;
  logic            pp_vld;
  logic [PW-1:0]   acc;
  logic [PW-1:0]   pp_sh;
  logic [DW-1:0]   rem;
  logic [PW-1:0]   qsh;
  logic [DW:0]     rem2;
  logic [DW:0]     rem_sub;
  logic            ge;
  logic [HW-1:0]   a_half;
  logic [HW-1:0]   b_half;
  logic signed [PW-1:0] prod_sh;
  word_t           mul_sat;
  word_t           div_sat;
  logic            q_hi_nz;
  logic [DW-1:0]   qlo;

  function automatic logic [DW-1:0] mag(word_t v);
    return v[DW-1] ? ({DW{1'b0}} - DW'(v)) : DW'(v);
  endfunction

  assign a_half = cnt[1] ? ua[DW-1:HW] : ua[HW-1:0];
  assign b_half = cnt[0] ? ub[DW-1:HW] : ub[HW-1:0];

  always_comb begin
    unique case (pp_k)
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << DW;
      default: pp_sh = PW'(pp) << HW;
    endcase
  end

  assign rem2    = {rem, qsh[PW-1]};
  assign rem_sub = rem2 - {1'b0, ub};
  assign ge      = rem2 >= {1'b0, ub};

  assign prod_sh = $signed(acc) >>> FRAC_BITS;
  assign mul_sat = ((&prod_sh[PW-1:DW-1]) || !(|prod_sh[PW-1:DW-1])) ? prod_sh[DW-1:0] :
                   (prod_sh[PW-1] ? WORD_MIN : WORD_MAX);

  assign q_hi_nz = |qsh[PW-1:DW];
  assign qlo     = qsh[DW-1:0];

  always_comb begin
    if (ub == '0) begin
      div_sat = '0;
    end else if (neg) begin
      div_sat = (q_hi_nz || (qlo > DW'(WORD_MIN))) ? WORD_MIN : word_t'({DW{1'b0}} - qlo);
    end else begin
      div_sat = (q_hi_nz || qlo[DW-1]) ? WORD_MAX : word_t'(qlo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (start) begin
            ua     <= mag(a);
            ub     <= mag(b);
            neg    <= a[DW-1] ^ b[DW-1];
            cnt    <= '0;
            acc    <= '0;
            pp_vld <= 1'b0;
            rem    <= '0;
            qsh    <= PW'(mag(a)) << FRAC_BITS;
            state  <= is_div ? MD_DIV : MD_MUL;
          end
        end
        MD_MUL: begin
          pp     <= a_half * b_half;
          pp_k   <= cnt[1:0];
          pp_vld <= !cnt[2];
          if (pp_vld) begin
            acc <= acc + pp_sh;
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd4) begin
            state <= MD_MNEG;
          end
        end
        MD_MNEG: begin
          if (neg) begin
            acc <= {PW{1'b0}} - acc;
          end
          state <= MD_MSAT;
        end
        MD_MSAT: begin
          result <= mul_sat;
          done   <= 1'b1;
          state  <= MD_IDLE;
        end
        MD_DIV: begin
          rem <= ge ? rem_sub[DW-1:0] : rem2[DW-1:0];
          qsh <= {qsh[PW-2:0], ge};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) begin
            state <= MD_DSAT;
          end
        end
        MD_DSAT: begin
          result <= div_sat;
          done   <= 1'b1;
          state  <= MD_IDLE;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/imac_dp.sv =====
`default_nettype none

module imac_dp (
  input  logic              clk,
  input  logic              rst,
  input  imac_pkg::dp_cmd_t cmd,
  output imac_pkg::dp_sts_t sts,
  input  imac_pkg::field_t  amount,
  input  imac_pkg::field_t  secondary,
  input  imac_pkg::field_t  centroid_x,
  input  imac_pkg::field_t  centroid_y,
  input  imac_pkg::field_t  centroid_z,
  input  imac_pkg::field_t  spin_in_x,
  input  imac_pkg::field_t  spin_in_y,
  input  imac_pkg::field_t  spin_in_z,
  input  imac_pkg::field_t  prod_in_xy,
  input  imac_pkg::field_t  prod_in_xz,
  input  imac_pkg::field_t  prod_in_yz,
  output logic              out_valid,
  input  logic              out_stall,
  output imac_pkg::word_t   total_amount,
  output imac_pkg::word_t   total_secondary,
  output imac_pkg::word_t   mean_x,
  output imac_pkg::word_t   mean_y,
  output imac_pkg::word_t   mean_z,
  output imac_pkg::word_t   spin_out_x,
  output imac_pkg::word_t   spin_out_y,
  output imac_pkg::word_t   spin_out_z,
  output imac_pkg::word_t   prod_out_xy,
  output imac_pkg::word_t   prod_out_xz,
  output imac_pkg::word_t   prod_out_yz,
  output logic              measure_ok
);
  import imac_pkg::*;

  word_t rf [RF_N];
  word_t opa;
  word_t opb;
  word_t rdata;
  ridx_t raddr;
  word_t alu_res;
  word_t mdu_res;
  word_t wdata;
  logic  wr;
  logic  mdu_done;

  function automatic word_t sat_add(word_t x, word_t y);
    logic signed [DW:0] s;
    s = {x[DW-1], x} + {y[DW-1], y};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? WORD_MIN : WORD_MAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic word_t sat_sub(word_t x, word_t y);
    logic signed [DW:0] s;
    s = {x[DW-1], x} - {y[DW-1], y};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? WORD_MIN : WORD_MAX;
    end
    return s[DW-1:0];
  endfunction

  assign raddr = cmd.rd_a ? cmd.uop.a : cmd.uop.b;
  assign rdata = rf[raddr];

  always_comb begin
    unique case (cmd.uop.op)
      OP_SUB:  alu_res = sat_sub(opa, opb);
      OP_ZERO: alu_res = '0;
      default: alu_res = sat_add(opa, opb);
    endcase
  end

  assign wr    = cmd.wr_alu | cmd.wr_mdu;
  assign wdata = cmd.wr_mdu ? mdu_res : alu_res;

  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      opa <= rdata;
    end
    if (cmd.rd_b) begin
      opb <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = int'(RI_A); i <= int'(RI_P2); i++) begin
        rf[ridx_t'(i)] <= '0;
      end
    end else begin
      if (cmd.ld_in) begin
        rf[RI_AMT] <= word_t'(amount);
        rf[RI_SEC] <= word_t'(secondary);
        rf[RI_CX]  <= word_t'(centroid_x);
        rf[RI_CY]  <= word_t'(centroid_y);
        rf[RI_CZ]  <= word_t'(centroid_z);
        rf[RI_SX]  <= word_t'(spin_in_x);
        rf[RI_SY]  <= word_t'(spin_in_y);
        rf[RI_SZ]  <= word_t'(spin_in_z);
        rf[RI_PXY] <= word_t'(prod_in_xy);
        rf[RI_PXZ] <= word_t'(prod_in_xz);
        rf[RI_PYZ] <= word_t'(prod_in_yz);
      end
      if (wr) begin
        rf[cmd.uop.dst] <= wdata;
      end
    end
  end

  imac_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start_mdu),
    .is_div (cmd.uop.op == OP_DIV),
    .a      (opa),
    .b      (opb),
    .done   (mdu_done),
    .result (mdu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      total_amount    <= rf[RI_A];
      total_secondary <= rf[RI_S];
      mean_x          <= rf[RI_T0];
      mean_y          <= rf[RI_T1];
      mean_z          <= rf[RI_T2];
      spin_out_x      <= rf[RI_SX];
      spin_out_y      <= rf[RI_SY];
      spin_out_z      <= rf[RI_SZ];
      prod_out_xy     <= rf[RI_PXY];
      prod_out_xz     <= rf[RI_PXZ];
      prod_out_yz     <= rf[RI_PYZ];
      measure_ok      <= (rf[RI_A] != '0);
    end
  end

  assign sts.mdu_done = mdu_done;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ===== design/imac_ctrl.sv =====
`default_nettype none

module imac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        measure_kind,
  output imac_pkg::dp_cmd_t cmd,
  input  imac_pkg::dp_sts_t sts
);
  import imac_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RDA  = 5'b00010,
    ST_RDB  = 5'b00100,
    ST_EXEC = 5'b01000,
    ST_WAIT = 5'b10000
  } state_t;

  state_t     state;
  state_t     state_next;
  pc_t        pc;
  pc_t        pc_next;
  logic [1:0] kind;
  uop_t       cur;

  assign cur       = prog(pc);
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next    = state;
    pc_next       = pc;
    cmd           = '0;
    cmd.uop       = cur;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          pc_next    = command ? PC_CLR : '0;
          state_next = ST_RDA;
        end
      end
      ST_RDA: begin
        unique case (cur.op)
          OP_END: begin
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          OP_JMP: pc_next = PC_OUT;
          default: begin
            cmd.rd_a   = 1'b1;
            state_next = ST_RDB;
          end
        endcase
      end
      ST_RDB: begin
        cmd.rd_b   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cur.op == OP_MUL || cur.op == OP_DIV) begin
          cmd.start_mdu = 1'b1;
          state_next    = ST_WAIT;
        end else begin
          cmd.wr_alu = !(cur.op == OP_ADDS && kind == MK_LENGTH);
          pc_next    = pc + 7'd1;
          state_next = ST_RDA;
        end
      end
      ST_WAIT: begin
        if (sts.mdu_done) begin
          cmd.wr_mdu = 1'b1;
          pc_next    = pc + 7'd1;
          state_next = ST_RDA;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      kind  <= MK_AREA;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (cfg_valid) begin
        kind <= measure_kind;
      end
    end
  end

  a_start_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.start_mdu |=> state == ST_WAIT)
    else $error("unit started without waiting");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    sts.mdu_done |-> state == ST_WAIT)
    else $error("unit done outside wait");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == ST_IDLE)
    else $error("result loaded but sequencer busy");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> pc < PC_N)
    else $error("pc beyond program");

endmodule

`default_nettype wire
